// File: rtl/lrp_pkg.sv
// package: shared types, action codes and constants of the lanczos resample pass
`default_nettype none

package lrp_pkg;

    localparam int DEF_MAX_LEN   = 4096;
    localparam int DEF_MAX_TAPS  = 32;
    localparam int DEF_FRAC_BITS = 22;

    localparam int OUT_LEN_W = 13;
    localparam logic [OUT_LEN_W-1:0] OUT_LEN_RESET = 13'd4096;

    localparam int PIX_W  = 24;
    localparam int WGT_W  = 32;
    localparam int PROD_W = 41;
    localparam int ACC_W  = 48;

    typedef enum logic [1:0] {
        ACT_SET_ROW     = 2'd0,
        ACT_LOAD_WEIGHT = 2'd1,
        ACT_WRITE_PIXEL = 2'd2,
        ACT_PRODUCE     = 2'd3
    } action_t;

    typedef struct packed {
        action_t            action;
        logic [11:0]        index;
        logic [4:0]         tap;
        logic [11:0]        start_req;
        logic [5:0]         tap_count;
        logic signed [31:0] weight;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
    } in_item_t;

    typedef struct packed {
        logic [11:0] out_index;
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic        bad_index;
    } out_item_t;

    typedef struct packed {
        logic init;
        logic tap_valid;
    } mac_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/lrp_mac.sv
// three-channel multiply-accumulate with rounding bias and output clamp
`default_nettype none

module lrp_mac #(
    parameter int FRAC_BITS = lrp_pkg::DEF_FRAC_BITS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire lrp_pkg::mac_ctrl_t                ctrl,
    input  wire logic [lrp_pkg::PIX_W-1:0]         pixel,
    input  wire logic signed [lrp_pkg::WGT_W-1:0]  weight,
    output logic                                   busy,
    output logic [7:0]                             red,
    output logic [7:0]                             green,
    output logic [7:0]                             blue
);

    localparam int PW = lrp_pkg::PROD_W;
    localparam int AW = lrp_pkg::ACC_W;

    logic signed [PW-1:0] prod_reg [3];
    logic                 prod_valid_reg;
    logic signed [AW-1:0] acc_reg  [3];
    logic [7:0]           chan [3];
    logic [7:0]           clamped [3];
    logic signed [AW-1:0] shifted [3];

    assign chan[0] = pixel[23:16];
    assign chan[1] = pixel[15:8];
    assign chan[2] = pixel[7:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else begin
            prod_valid_reg <= ctrl.tap_valid;
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < 3; c++) begin
            prod_reg[c] <= $signed({1'b0, chan[c]}) * weight;
            if (ctrl.init) begin
                acc_reg[c] <= AW'(1) << (FRAC_BITS - 1);
            end else if (prod_valid_reg) begin
                acc_reg[c] <= acc_reg[c] + AW'(prod_reg[c]);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            shifted[c] = acc_reg[c] >>> FRAC_BITS;
            if (acc_reg[c][AW-1]) begin
                clamped[c] = 8'd0;
            end else if (shifted[c] > AW'(255)) begin
                clamped[c] = 8'd255;
            end else begin
                clamped[c] = shifted[c][7:0];
            end
        end
    end

    assign busy  = prod_valid_reg;
    assign red   = clamped[0];
    assign green = clamped[1];
    assign blue  = clamped[2];

endmodule

`default_nettype wire

// File: rtl/lanczos_resample_pass.sv
// top level: one pass of separable lanczos rgb resampling over a stored line
//
// input transactions on s_valid/s_ready carry one action each: set a row's
// start and tap count, load one weight, write one pixel, or produce a result.
// only a produce transaction yields a result transaction on m_valid/m_ready.
// out_len is written through cfg_wen/cfg_wdata; the user must write it only
// while the block is idle, as the block itself does not enforce this. the
// block handles one transaction at a time. a write completes on acceptance
// and the next transaction can be taken in the following cycle. a produce
// reads its row entry, then one tap per cycle from the weight and line
// memories through a registered multiply and an accumulate, paced by the
// single read port of each memory, and loads its result into the output
// register; a bad index skips to that load. after reset a clearing pass
// zeroes the tap counts of all MAX_LEN row entries while s_ready stays low.
// a result waits in the output register while m_ready is low, and the block
// holds the next result until that one is taken.
`default_nettype none

module lanczos_resample_pass #(
    parameter int MAX_LEN   = lrp_pkg::DEF_MAX_LEN,
    parameter int MAX_TAPS  = lrp_pkg::DEF_MAX_TAPS,
    parameter int FRAC_BITS = lrp_pkg::DEF_FRAC_BITS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire lrp_pkg::in_item_t                 s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output lrp_pkg::out_item_t                     m_data,
    input  wire logic                              cfg_wen,
    input  wire logic [lrp_pkg::OUT_LEN_W-1:0]     cfg_wdata
);

    localparam int LAW    = $clog2(MAX_LEN);
    localparam int TAP_AW = $clog2(MAX_TAPS);
    localparam int TW     = $clog2(MAX_TAPS + 1);
    localparam int ROW_W  = 12 + TW;
    localparam int WDEPTH = MAX_LEN << TAP_AW;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ROW   = 5'b00010,
        ST_TAP   = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                        state_reg, state_next;
    logic [11:0]                   idx_reg, idx_next;
    logic                          bad_reg, bad_next;
    logic [TW-1:0]                 taps_reg, taps_next;
    logic [11:0]                   base_reg, base_next;
    logic [TW-1:0]                 k_reg, k_next;
    logic                          rd_valid_reg, rd_valid_next;
    logic                          clearing_reg;
    logic [LAW-1:0]                clr_cnt_reg;
    logic [lrp_pkg::OUT_LEN_W-1:0] out_len_reg;
    logic                          m_valid_reg, m_valid_next;
    lrp_pkg::out_item_t            m_data_reg, m_data_next;

    logic [lrp_pkg::PIX_W-1:0]        line_mem [MAX_LEN];
    logic [ROW_W-1:0]                 row_mem  [MAX_LEN];
    logic [lrp_pkg::WGT_W-1:0]        wgt_mem  [WDEPTH];
    logic [lrp_pkg::PIX_W-1:0]        line_rd_reg;
    logic [ROW_W-1:0]                 row_rd_reg;
    logic [lrp_pkg::WGT_W-1:0]        wgt_rd_reg;

    logic               accept;
    logic               idx_ok;
    logic               row_we;
    logic [LAW-1:0]     row_waddr;
    logic [ROW_W-1:0]   row_wdata;
    logic [TW-1:0]      taps_sat;
    logic [12:0]        pos;
    logic               issue;
    lrp_pkg::mac_ctrl_t mac_ctrl;
    logic               mac_busy;
    logic [7:0]         mac_red, mac_green, mac_blue;

    assign s_ready = (state_reg == ST_IDLE) && !clearing_reg;
    assign accept  = s_valid && s_ready;
    assign idx_ok  = 32'(s_data.index) < MAX_LEN;

    assign taps_sat = (32'(s_data.tap_count) > MAX_TAPS) ? TW'(MAX_TAPS)
                                                          : TW'(s_data.tap_count);

    assign row_we    = clearing_reg ||
                       (accept && idx_ok && s_data.action == lrp_pkg::ACT_SET_ROW);
    assign row_waddr = clearing_reg ? clr_cnt_reg : LAW'(s_data.index);
    assign row_wdata = clearing_reg ? '0 : {s_data.start_req, taps_sat};

    assign pos   = {1'b0, base_reg} + 13'(k_reg);
    assign issue = (state_reg == ST_TAP) && (k_reg < taps_reg);

    // memories
    always_ff @(posedge aclk) begin
        if (row_we) begin
            row_mem[row_waddr] <= row_wdata;
        end
        row_rd_reg <= row_mem[LAW'(s_data.index)];
    end

    always_ff @(posedge aclk) begin
        if (accept && idx_ok && s_data.action == lrp_pkg::ACT_WRITE_PIXEL) begin
            line_mem[LAW'(s_data.index)] <= {s_data.red_in, s_data.green_in,
                                             s_data.blue_in};
        end
        line_rd_reg <= line_mem[LAW'(pos)];
    end

    always_ff @(posedge aclk) begin
        if (accept && idx_ok && (32'(s_data.tap) < MAX_TAPS) &&
            s_data.action == lrp_pkg::ACT_LOAD_WEIGHT) begin
            wgt_mem[{LAW'(s_data.index), TAP_AW'(s_data.tap)}] <= s_data.weight;
        end
        wgt_rd_reg <= wgt_mem[{LAW'(idx_reg), TAP_AW'(k_reg)}];
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        bad_next      = bad_reg;
        taps_next     = taps_reg;
        base_next     = base_reg;
        k_next        = k_reg;
        rd_valid_next = issue && (32'(pos) < MAX_LEN);
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        mac_ctrl.init      = 1'b0;
        mac_ctrl.tap_valid = rd_valid_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept && s_data.action == lrp_pkg::ACT_PRODUCE) begin
                    idx_next   = s_data.index;
                    bad_next   = !idx_ok || ({1'b0, s_data.index} >= out_len_reg);
                    state_next = (!idx_ok || ({1'b0, s_data.index} >= out_len_reg))
                                 ? ST_DONE : ST_ROW;
                end
            end
            ST_ROW: begin
                base_next     = row_rd_reg[ROW_W-1:TW];
                taps_next     = row_rd_reg[TW-1:0];
                k_next        = '0;
                mac_ctrl.init = 1'b1;
                state_next    = ST_TAP;
            end
            ST_TAP: begin
                if (issue) begin
                    k_next = k_reg + TW'(1);
                end else begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_valid_reg && !mac_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.out_index = idx_reg;
                    m_data_next.bad_index = bad_reg;
                    m_data_next.red_out   = bad_reg ? 8'd0 : mac_red;
                    m_data_next.green_out = bad_reg ? 8'd0 : mac_green;
                    m_data_next.blue_out  = bad_reg ? 8'd0 : mac_blue;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            out_len_reg  <= lrp_pkg::OUT_LEN_RESET;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
            if (clearing_reg) begin
                clr_cnt_reg <= clr_cnt_reg + LAW'(1);
                if (32'(clr_cnt_reg) == MAX_LEN - 1) begin
                    clearing_reg <= 1'b0;
                end
            end
            if (cfg_wen) begin
                out_len_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        bad_reg    <= bad_next;
        taps_reg   <= taps_next;
        base_reg   <= base_next;
        k_reg      <= k_next;
        m_data_reg <= m_data_next;
    end

    lrp_mac #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mac (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctrl   (mac_ctrl),
        .pixel  (line_rd_reg),
        .weight (wgt_rd_reg),
        .busy   (mac_busy),
        .red    (mac_red),
        .green  (mac_green),
        .blue   (mac_blue)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// File: rtl/lrp_checker.sv
// checker: port-level assertions for the lanczos resample pass, with bind
`default_nettype none

module lrp_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire lrp_pkg::in_item_t  s_data,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire lrp_pkg::out_item_t m_data
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a bad index gives zero channels
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_index |->
            m_data.red_out == 8'd0 && m_data.green_out == 8'd0 &&
            m_data.blue_out == 8'd0)
        else $error("bad index result with nonzero channels");

    // s_ready is low in the cycle after a produce is taken
    a_produce_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.action == lrp_pkg::ACT_PRODUCE |=> !s_ready)
        else $error("input taken right after a produce transaction");

    // reset starts the clearing pass and empties the output
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block not quiet after reset");

endmodule

bind lanczos_resample_pass lrp_checker u_lrp_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_data (s_data),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

`default_nettype wire

// File: tb/lanczos_resample_pass_test.sv
// testbench: directed and random transactions checked against a lanczos resampling predictor
`timescale 1ns / 1ps

module lanczos_resample_pass_test;
    import lrp_pkg::*;

    localparam int LINE_LEN       = DEF_MAX_LEN;
    localparam int TAPS           = DEF_MAX_TAPS;
    localparam int FRAC           = DEF_FRAC_BITS;
    localparam int PHASE_ITEMS    = 175;
    localparam int DRAIN_CYCLES   = 64;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int HOLD_AT_RESULT = 40;
    localparam int HOLD_CYCLES    = 500;

    typedef struct {
        logic [OUT_LEN_W-1:0] cfg;
        in_item_t             item;
        bit                   typed;
        out_item_t            result;
    } stim_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;
    logic                 cfg_wen   = 1'b0;
    logic [OUT_LEN_W-1:0] cfg_wdata = '0;

    // predictor copy of the block state
    logic [23:0]          line_px   [LINE_LEN];
    logic [11:0]          row_first [LINE_LEN];
    bit   [5:0]           row_len   [LINE_LEN];
    logic [31:0]          coef      [LINE_LEN*TAPS];
    bit                   px_set    [LINE_LEN];
    bit                   row_set   [LINE_LEN];
    bit                   coef_set  [LINE_LEN*TAPS];
    logic [OUT_LEN_W-1:0] model_out_len = OUT_LEN_RESET;

    out_item_t   expected_pixels [$];
    logic [11:0] last_row       = '0;
    int          errors         = 0;
    int          results_seen   = 0;
    int          items_sent     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          cycle_count    = 0;

    lanczos_resample_pass DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("lanczos_resample_pass test failed");
            $finish;
        end
    end

    function automatic logic [7:0] clamp_channel_sum(input longint acc);
        longint v;
        if (acc < 0) return 8'd0;
        v = acc >>> FRAC;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic out_item_t resample_predict(input logic [11:0] idx);
        out_item_t r;
        longint    acc [3];
        longint    w;
        int        pos, k, c;
        r = '0;
        r.out_index = idx;
        if (idx >= model_out_len) begin
            r.bad_index = 1'b1;
            return r;
        end
        for (c = 0; c < 3; c++) acc[c] = longint'(1) << (FRAC - 1);
        for (k = 0; k < row_len[idx]; k++) begin
            pos = row_first[idx] + k;
            if (pos < LINE_LEN) begin
                w = longint'($signed(coef[idx*TAPS + k]));
                acc[0] += longint'(line_px[pos][23:16]) * w;
                acc[1] += longint'(line_px[pos][15:8]) * w;
                acc[2] += longint'(line_px[pos][7:0]) * w;
            end
        end
        r.red_out   = clamp_channel_sum(acc[0]);
        r.green_out = clamp_channel_sum(acc[1]);
        r.blue_out  = clamp_channel_sum(acc[2]);
        return r;
    endfunction

    // true when a produce on idx touches only written entries, or idx is a bad index
    function automatic bit row_readable(input logic [11:0] idx);
        int pos, k;
        if (idx >= model_out_len) return 1'b1;
        if (!row_set[idx]) return 1'b0;
        for (k = 0; k < row_len[idx]; k++) begin
            pos = row_first[idx] + k;
            if (!coef_set[idx*TAPS + k]) return 1'b0;
            if (pos < LINE_LEN && !px_set[pos]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic in_item_t random_fill();
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        return bits[$bits(in_item_t)-1:0];
    endfunction

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
            2: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
            default: return $urandom_range(32'h0030_0000, 32'h0050_0000);
        endcase
    endfunction

    function automatic logic [11:0] pick_row_index();
        if ($urandom_range(9) < 8) return 12'($urandom_range(0, model_out_len - 1));
        return 12'($urandom_range(0, LINE_LEN - 1));
    endfunction

    function automatic stim_row_t dir_row(input int cfg, input action_t act, input int idx,
                                          input int tap, input int start, input int cnt,
                                          input logic [31:0] w, input logic [23:0] rgb,
                                          input bit typed, input logic [23:0] exp_rgb,
                                          input bit bad);
        stim_row_t row;
        row.cfg            = cfg[OUT_LEN_W-1:0];
        row.item           = '0;
        row.item.action    = act;
        row.item.index     = idx[11:0];
        row.item.tap       = tap[4:0];
        row.item.start_req = start[11:0];
        row.item.tap_count = cnt[5:0];
        row.item.weight    = w;
        row.item.red_in    = rgb[23:16];
        row.item.green_in  = rgb[15:8];
        row.item.blue_in   = rgb[7:0];
        row.typed          = typed;
        row.result         = {idx[11:0], exp_rgb, bad};
        return row;
    endfunction

    task automatic offer_transaction(input in_item_t it, input bit typed = 1'b0,
                                     input out_item_t typed_res = '0);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do begin
                @(posedge aclk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        items_sent++;
        case (it.action)
            ACT_SET_ROW: begin
                row_first[it.index] = it.start_req;
                row_len[it.index]   = (it.tap_count > TAPS) ? 6'(TAPS) : it.tap_count;
                row_set[it.index]   = 1'b1;
            end
            ACT_LOAD_WEIGHT: begin
                coef[it.index*TAPS + it.tap]     = it.weight;
                coef_set[it.index*TAPS + it.tap] = 1'b1;
            end
            ACT_WRITE_PIXEL: begin
                line_px[it.index] = {it.red_in, it.green_in, it.blue_in};
                px_set[it.index]  = 1'b1;
            end
            default: begin
                expected_pixels = {expected_pixels,
                                   typed ? typed_res : resample_predict(it.index)};
            end
        endcase
    endtask

    task automatic set_out_len(input logic [OUT_LEN_W-1:0] len);
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (expected_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= len;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        model_out_len = len;
    endtask

    // set a row, load its weights, write its pixels, then produce it
    task automatic run_row_sequence();
        in_item_t    it;
        logic [11:0] idx, start;
        int          cnt, used, pos, k, sel;
        idx = pick_row_index();
        sel = $urandom_range(99);
        if (sel < 5) cnt = 0;
        else if (sel < 85) cnt = $urandom_range(1, 6);
        else if (sel < 95) cnt = $urandom_range(7, 32);
        else cnt = $urandom_range(33, 63);
        if ($urandom_range(9) == 0) start = 12'($urandom_range(LINE_LEN - 8, LINE_LEN - 1));
        else start = 12'($urandom_range(0, LINE_LEN - 1));
        it = random_fill();
        it.action    = ACT_SET_ROW;
        it.index     = idx;
        it.start_req = start;
        it.tap_count = cnt[5:0];
        offer_transaction(it);
        used = (cnt > TAPS) ? TAPS : cnt;
        for (k = 0; k < used; k++) begin
            it = random_fill();
            it.action = ACT_LOAD_WEIGHT;
            it.index  = idx;
            it.tap    = k[4:0];
            it.weight = pick_weight();
            offer_transaction(it);
        end
        for (k = 0; k < used; k++) begin
            pos = start + k;
            if (pos < LINE_LEN && (!px_set[pos] || $urandom_range(1) == 0)) begin
                it = random_fill();
                it.action = ACT_WRITE_PIXEL;
                it.index  = pos[11:0];
                offer_transaction(it);
            end
        end
        last_row = idx;
        repeat ($urandom_range(1, 4)) begin
            it = random_fill();
            it.action = ACT_PRODUCE;
            it.index  = idx;
            offer_transaction(it);
        end
    endtask

    task automatic run_noise_item();
        in_item_t it;
        it = random_fill();
        if (it.action == ACT_PRODUCE) begin
            case ($urandom_range(2))
                0: it.index = last_row;
                1: it.index = pick_row_index();
                default: ;
            endcase
            if (!row_readable(it.index) && model_out_len < LINE_LEN)
                it.index = 12'($urandom_range(model_out_len, LINE_LEN - 1));
            if (row_readable(it.index)) offer_transaction(it);
        end else begin
            offer_transaction(it);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    initial begin : result_sink
        int        hold_left;
        out_item_t want;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected result transaction, out_index %0d", m_data.out_index);
                    errors++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("out_index", want.out_index, m_data.out_index);
                    check_field("red_out",   want.red_out,   m_data.red_out);
                    check_field("green_out", want.green_out, m_data.green_out);
                    check_field("blue_out",  want.blue_out,  m_data.blue_out);
                    check_field("bad_index", want.bad_index, m_data.bad_index);
                end
                results_seen++;
                if (results_seen == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin : stimulus
        stim_row_t            rows [$];
        logic [OUT_LEN_W-1:0] phase_len [4];
        int                   phase_send [4];
        int                   phase_stall [4];
        int                   phase, start_count;

        // cfg, action, index, tap, start, taps, weight, rgb, typed, expected rgb, bad
        rows = {rows, dir_row(0, ACT_SET_ROW,     5,    0, 0,    0, 32'h0, 24'h0,      0, 0, 0)};
        rows = {rows, dir_row(0, ACT_PRODUCE,     5,    0, 0,    0, 32'h0, 24'h0,      1, 24'h0, 0)};
        rows = {rows, dir_row(0, ACT_WRITE_PIXEL, 4095, 0, 0,    0, 32'h0, 24'hff0080, 0, 0, 0)};
        rows = {rows, dir_row(0, ACT_WRITE_PIXEL, 0,    0, 0,    0, 32'h0, 24'h00ff01, 0, 0, 0)};
        rows = {rows, dir_row(0, ACT_WRITE_PIXEL, 4094, 0, 0,    0, 32'h0, 24'hffffff, 0, 0, 0)};
        rows = {rows, dir_row(0, ACT_SET_ROW,     4095, 0, 4095, 2, 32'h0, 24'h0,      0, 0, 0)};
        rows = {rows, dir_row(0, ACT_LOAD_WEIGHT, 4095, 0, 0, 0, 32'h0040_0000, 0,     0, 0, 0)};
        rows = {rows, dir_row(0, ACT_LOAD_WEIGHT, 4095, 1, 0, 0, 32'h7fff_ffff, 0,     0, 0, 0)};
        rows = {rows, dir_row(0, ACT_PRODUCE,     4095, 0, 0,    0, 32'h0, 24'h0,      1, 24'hff0080, 0)};
        rows = {rows, dir_row(0, ACT_SET_ROW,     1,    0, 4094, 2, 32'h0, 24'h0,      0, 0, 0)};
        rows = {rows, dir_row(0, ACT_LOAD_WEIGHT, 1,    0, 0, 0, 32'h8000_0000, 0,     0, 0, 0)};
        rows = {rows, dir_row(0, ACT_LOAD_WEIGHT, 1,    1, 0, 0, 32'h7fff_ffff, 0,     0, 0, 0)};
        rows = {rows, dir_row(0, ACT_PRODUCE,     1,    0, 0,    0, 32'h0, 24'h0,      0, 0, 0)};
        rows = {rows, dir_row(0, ACT_SET_ROW,     2,    0, 0,    1, 32'h0, 24'h0,      0, 0, 0)};
        rows = {rows, dir_row(0, ACT_LOAD_WEIGHT, 2,    0, 0, 0, 32'h7fff_ffff, 0,     0, 0, 0)};
        rows = {rows, dir_row(0, ACT_PRODUCE,     2,    0, 0,    0, 32'h0, 24'h0,      0, 0, 0)};
        rows = {rows, dir_row(0, ACT_LOAD_WEIGHT, 2,   31, 0, 0, 32'hffff_ffff, 0,     0, 0, 0)};
        rows = {rows, dir_row(0, ACT_SET_ROW,     3,    0, 4095, 1, 32'h0, 24'h0,      0, 0, 0)};
        rows = {rows, dir_row(0, ACT_LOAD_WEIGHT, 3,    0, 0, 0, 32'hffc0_0000, 0,     0, 0, 0)};
        rows = {rows, dir_row(0, ACT_PRODUCE,     3,    0, 0,    0, 32'h0, 24'h0,      1, 24'h0, 0)};
        rows = {rows, dir_row(1, ACT_PRODUCE,     1,    0, 0,    0, 32'h0, 24'h0,      1, 24'h0, 1)};
        rows = {rows, dir_row(0, ACT_PRODUCE,     4095, 0, 0,    0, 32'h0, 24'h0,      1, 24'h0, 1)};
        rows = {rows, dir_row(6, ACT_PRODUCE,     5,    0, 0,    0, 32'h0, 24'h0,      1, 24'h0, 0)};
        rows = {rows, dir_row(0, ACT_PRODUCE,     6,    0, 0,    0, 32'h0, 24'h0,      1, 24'h0, 1)};
        rows = {rows, dir_row(4096, ACT_PRODUCE,  4095, 0, 0,    0, 32'h0, 24'h0,      1, 24'hff0080, 0)};

        phase_len[0] = 13'($urandom_range(2, LINE_LEN - 1));
        phase_len[1] = 13'(LINE_LEN);
        phase_len[2] = 13'd1;
        phase_len[3] = 13'($urandom_range(2, LINE_LEN - 1));
        phase_send  = '{0, 58, 0, 17};
        phase_stall = '{0, 0, 58, 17};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].cfg != 0) set_out_len(rows[i].cfg);
            offer_transaction(rows[i].item, rows[i].typed, rows[i].result);
        end

        for (phase = 0; phase < 4; phase++) begin
            set_out_len(phase_len[phase]);
            send_idle_pct  = phase_send[phase];
            recv_stall_pct = phase_stall[phase];
            start_count    = items_sent;
            while (items_sent - start_count < PHASE_ITEMS) begin
                if ($urandom_range(3) != 0) run_row_sequence();
                else run_noise_item();
            end
        end

        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (expected_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("lanczos_resample_pass test passed");
        end else begin
            $display("lanczos_resample_pass test failed");
        end
        $finish;
    end

endmodule
